>>> hw/rtl/m4t_pkg.sv
// ----------------------------------------------------------------------------
// m4t_pkg
// Shared types and constants for the 4x4 matrix transform unit.
// ----------------------------------------------------------------------------
package m4t_pkg;

  localparam int DATA_W      = 32;
  localparam int NUM_LANES   = 4;
  localparam int NUM_ENTRIES = NUM_LANES * NUM_LANES;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] OPC_LOAD  = 3'd0;
  localparam logic [2:0] OPC_READ  = 3'd1;
  localparam logic [2:0] OPC_MXV   = 3'd2;
  localparam logic [2:0] OPC_VXM   = 3'd3;
  localparam logic [2:0] OPC_SCALE = 3'd4;

  typedef enum logic [2:0] {
    K_LOAD,
    K_READ,
    K_MXV,
    K_VXM,
    K_SCALE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                            kind;
    logic [1:0]                       row;
    logic [NUM_LANES-1:0][DATA_W-1:0] vec;
  } item_t;

endpackage

>>> hw/rtl/m4t_front.sv
// ----------------------------------------------------------------------------
// m4t_front
// Accepts input items and decodes opcode and row index for the queue.
// ----------------------------------------------------------------------------
module m4t_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           opcode,
  input  logic signed [3:0]    row_index,
  input  logic signed [31:0]   vec_x,
  input  logic signed [31:0]   vec_y,
  input  logic signed [31:0]   vec_z,
  input  logic signed [31:0]   vec_w,
  input  logic                 q_full,
  output logic                 push,
  output m4t_pkg::item_t       push_item
);
  import m4t_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    unique case (opcode)
      OPC_LOAD:  push_item.kind = K_LOAD;
      OPC_READ:  push_item.kind = K_READ;
      OPC_MXV:   push_item.kind = K_MXV;
      OPC_VXM:   push_item.kind = K_VXM;
      OPC_SCALE: push_item.kind = K_SCALE;
      default:   push_item.kind = K_NOP;
    endcase
    // negative or 4..7 falls back to row 0
    push_item.row = (row_index[3:2] == 2'b00) ? row_index[1:0] : 2'd0;
    push_item.vec[0] = vec_x;
    push_item.vec[1] = vec_y;
    push_item.vec[2] = vec_z;
    push_item.vec[3] = vec_w;
  end

endmodule

>>> hw/rtl/m4t_queue.sv
// ----------------------------------------------------------------------------
// m4t_queue
// Short item queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module m4t_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  m4t_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output m4t_pkg::item_t  q_item
);
  import m4t_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

>>> hw/rtl/m4t_back.sv
// ----------------------------------------------------------------------------
// m4t_back
// Holds the matrix and runs items through operand select, sixteen
// multipliers, pair sums and final sum with shift and clamp.
// ----------------------------------------------------------------------------
module m4t_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  m4t_pkg::item_t      q_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  res_x,
  output logic signed [31:0]  res_y,
  output logic signed [31:0]  res_z,
  output logic signed [31:0]  res_w,
  output logic                saturated
);
  import m4t_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  MAX_V = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0]  MIN_V = -SUM_W'(64'sh8000_0000);

  function automatic logic [DATA_W:0] clamp32(input logic signed [SUM_W-1:0] q);
    if (q > MAX_V) return {1'b1, 32'h7FFF_FFFF};
    if (q < MIN_V) return {1'b1, 32'h8000_0000};
    return {1'b0, q[DATA_W-1:0]};
  endfunction

  logic signed [DATA_W-1:0] mat [NUM_ENTRIES];

  logic en;
  logic scale_busy;

  // stage 1: operands
  logic                     v1;
  kind_t                    k1;
  logic signed [DATA_W-1:0] a1 [NUM_ENTRIES];
  logic signed [DATA_W-1:0] b1 [NUM_ENTRIES];
  logic [DATA_W-1:0]        pass1 [NUM_LANES];
  logic signed [DATA_W-1:0] a_next [NUM_ENTRIES];
  logic signed [DATA_W-1:0] b_next [NUM_ENTRIES];
  logic [DATA_W-1:0]        pass_next [NUM_LANES];

  // stage 2: products
  logic                     v2;
  kind_t                    k2;
  logic signed [PROD_W-1:0] prod2 [NUM_ENTRIES];
  logic [DATA_W-1:0]        pass2 [NUM_LANES];

  // stage 3: pair sums and per-entry clamp
  logic                     v3;
  kind_t                    k3;
  logic signed [PAIR_W-1:0] pair3 [2*NUM_LANES];
  logic [DATA_W-1:0]        scl3 [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]   scl_sat3;
  logic [DATA_W-1:0]        pass3 [NUM_LANES];
  logic [DATA_W:0]          scl_c [NUM_ENTRIES];

  // output register
  logic [DATA_W-1:0]        res_next [NUM_LANES];
  logic                     sat_next;
  logic [DATA_W-1:0]        res [NUM_LANES];
  logic                     sat_q;
  logic signed [SUM_W-1:0]  sum_c [NUM_LANES];
  logic [DATA_W:0]          sum_clamp [NUM_LANES];

  logic load_we;
  logic scale_we;

  assign en         = !out_valid || !out_stall;
  assign scale_busy = (v1 && k1 == K_SCALE) || (v2 && k2 == K_SCALE) ||
                      (v3 && k3 == K_SCALE);
  assign pop        = q_valid && en && !scale_busy;
  assign load_we    = pop && q_item.kind == K_LOAD;
  assign scale_we   = en && v3 && k3 == K_SCALE;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      for (int t = 0; t < NUM_LANES; t++) begin
        case (q_item.kind)
          K_MXV: begin
            a_next[k*4+t] = mat[k*4+t];
            b_next[k*4+t] = q_item.vec[t];
          end
          K_VXM: begin
            a_next[k*4+t] = mat[t*4+k];
            b_next[k*4+t] = q_item.vec[t];
          end
          K_SCALE: begin
            a_next[k*4+t] = mat[k*4+t];
            b_next[k*4+t] = q_item.vec[0];
          end
          default: begin
            a_next[k*4+t] = '0;
            b_next[k*4+t] = '0;
          end
        endcase
      end
    end
    for (int j = 0; j < NUM_LANES; j++) begin
      case (q_item.kind)
        K_LOAD:  pass_next[j] = q_item.vec[j];
        K_READ:  pass_next[j] = mat[{q_item.row, 2'(j)}];
        default: pass_next[j] = '0;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      scl_c[i] = clamp32(SUM_W'(prod2[i] >>> FRAC_BITS));
    end
    for (int k = 0; k < NUM_LANES; k++) begin
      sum_c[k]     = (SUM_W'(pair3[2*k]) + SUM_W'(pair3[2*k+1])) >>> FRAC_BITS;
      sum_clamp[k] = clamp32(sum_c[k]);
    end
    sat_next = 1'b0;
    for (int k = 0; k < NUM_LANES; k++) begin
      case (k3) inside
        K_LOAD, K_READ: res_next[k] = pass3[k];
        K_MXV, K_VXM: begin
          res_next[k] = sum_clamp[k][DATA_W-1:0];
          sat_next    = sat_next | sum_clamp[k][DATA_W];
        end
        default: res_next[k] = '0;
      endcase
    end
    if (k3 == K_SCALE) sat_next = |scl_sat3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        mat[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else begin
      if (en) begin
        v1        <= pop;
        v2        <= v1;
        v3        <= v2;
        out_valid <= v3;
      end
      if (load_we) begin
        for (int j = 0; j < NUM_LANES; j++) begin
          mat[{q_item.row, 2'(j)}] <= q_item.vec[j];
        end
      end
      if (scale_we) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          mat[i] <= scl3[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= q_item.kind;
      k2 <= k1;
      k3 <= k2;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        a1[i]       <= a_next[i];
        b1[i]       <= b_next[i];
        prod2[i]    <= a1[i] * b1[i];
        scl3[i]     <= scl_c[i][DATA_W-1:0];
        scl_sat3[i] <= scl_c[i][DATA_W];
      end
      for (int k = 0; k < 2 * NUM_LANES; k++) begin
        pair3[k] <= PAIR_W'(prod2[2*k]) + PAIR_W'(prod2[2*k+1]);
      end
      for (int j = 0; j < NUM_LANES; j++) begin
        pass1[j] <= pass_next[j];
        pass2[j] <= pass1[j];
        pass3[j] <= pass2[j];
        res[j]   <= res_next[j];
      end
      sat_q <= sat_next;
    end
  end

  assign res_x     = res[0];
  assign res_y     = res[1];
  assign res_z     = res[2];
  assign res_w     = res[3];
  assign saturated = sat_q;

`ifndef ASSERT_OFF
  a_no_issue_on_scale: assert property (@(posedge clk) disable iff (rst)
    pop |-> !scale_busy)
    else $error("item issued while scale in flight");
  a_one_scale: assert property (@(posedge clk) disable iff (rst)
    $countones({v1 && k1 == K_SCALE, v2 && k2 == K_SCALE, v3 && k3 == K_SCALE}) <= 1)
    else $error("more than one scale in flight");
  a_scale_flag: assert property (@(posedge clk) disable iff (rst)
    scale_we |=> out_valid && saturated == $past(|scl_sat3))
    else $error("scale saturation flag lost");
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(load_we && scale_we))
    else $error("load and scale write the matrix together");
`endif

endmodule

>>> hw/rtl/matrix4_transform_unit_top.sv
// throughput: one item per cycle while out_stall is low; a scale holds back
//   later items until its result writes the matrix at the last pipeline stage
// reset: matrix returns to identity, queue and pipeline empty
// ----------------------------------------------------------------------------
// matrix4_transform_unit_top
// 4x4 fixed-point matrix engine: decode front, item queue, execution back.
// ----------------------------------------------------------------------------
module matrix4_transform_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          opcode,
  input  logic signed [3:0]   row_index,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  input  logic signed [31:0]  vec_w,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  res_x,
  output logic signed [31:0]  res_y,
  output logic signed [31:0]  res_z,
  output logic signed [31:0]  res_w,
  output logic                saturated
);
  import m4t_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  m4t_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row_index (row_index),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .vec_w     (vec_w),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  m4t_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  m4t_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_w     (res_w),
    .saturated (saturated)
  );

endmodule

>>> test/tb_matrix4_transform_unit_top.sv
// ----------------------------------------------------------------------------
// tb_matrix4_transform_unit_top
// Self-checking bench for the 4x4 fixed-point matrix engine. A scoreboard
// class keeps its own copy of the matrix and predicts every result: row
// load and read, matrix times vector, vector times matrix and scale, with
// floor shift and 32-bit clamping. Directed corner items come first, then
// random row loads followed by bursts of random operations. The run passes
// through four phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_matrix4_transform_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  import m4t_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 400;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef logic [NUM_LANES-1:0][DATA_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t lane;
    logic   sat;
  } result_t;

  class m4t_scoreboard #(int FRAC = 16);
    logic signed [31:0] matrix [NUM_ENTRIES];
    result_t            expected_rows[$];
    int                 errors;

    function void reset_matrix();
      foreach (matrix[i]) matrix[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
    endfunction

    // floor shift of the exact sum, then clamp to 32 bits
    function logic signed [31:0] shift_clamp(logic signed [65:0] acc, inout logic sat);
      logic signed [65:0] q;
      q = acc >>> FRAC;
      if (q > 66'sd2147483647) begin
        sat = 1'b1;
        return Q_MAX;
      end
      if (q < -66'sd2147483648) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return q[31:0];
    endfunction

    function void predict_item(logic [2:0] op, logic signed [3:0] row_sel, lanes_t v);
      result_t            r;
      logic               sat;
      int                 base;
      logic signed [65:0] acc;
      logic signed [31:0] a;
      logic signed [31:0] b;
      r    = '0;
      sat  = 1'b0;
      base = (row_sel >= 0 && row_sel <= 3) ? 4 * row_sel : 0;
      case (op)
        OPC_LOAD: begin
          for (int j = 0; j < 4; j++) begin
            matrix[base + j] = v[j];
            r.lane[j]        = v[j];
          end
        end
        OPC_READ: begin
          for (int j = 0; j < 4; j++) r.lane[j] = matrix[base + j];
        end
        OPC_MXV: begin
          for (int i = 0; i < 4; i++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
              a   = matrix[4 * i + j];
              b   = v[j];
              acc = acc + a * b;
            end
            r.lane[i] = shift_clamp(acc, sat);
          end
        end
        OPC_VXM: begin
          for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int i = 0; i < 4; i++) begin
              a   = v[i];
              b   = matrix[4 * i + j];
              acc = acc + a * b;
            end
            r.lane[j] = shift_clamp(acc, sat);
          end
        end
        OPC_SCALE: begin
          b = v[0];
          for (int k = 0; k < NUM_ENTRIES; k++) begin
            a         = matrix[k];
            acc       = a * b;
            matrix[k] = shift_clamp(acc, sat);
          end
        end
        default: ;
      endcase
      r.sat = sat;
      expected_rows.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(lanes_t got, logic got_sat);
      result_t want;
      string   lane_name [4];
      lane_name = '{"res_x", "res_y", "res_z", "res_w"};
      if (expected_rows.size() == 0) begin
        report("result with no item pending");
        return;
      end
      want = expected_rows.pop_front();
      for (int j = 0; j < 4; j++) begin
        if (got[j] !== want.lane[j]) begin
          report($sformatf("%s got %h want %h", lane_name[j], got[j], want.lane[j]));
        end
      end
      if (got_sat !== want.sat) begin
        report($sformatf("saturated got %b want %b", got_sat, want.sat));
      end
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [2:0]         opcode    = '0;
  logic signed [3:0]  row_index = '0;
  logic signed [31:0] vec_x     = '0;
  logic signed [31:0] vec_y     = '0;
  logic signed [31:0] vec_z     = '0;
  logic signed [31:0] vec_w     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [31:0] res_w;
  logic               saturated;

  m4t_scoreboard #(FRAC_BITS) sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  matrix4_transform_unit_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row_index (row_index),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .vec_w     (vec_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_w     (res_w),
    .saturated (saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check accepted items, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({res_w, res_z, res_y, res_x}, saturated);
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic lanes_t pack4(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic signed [31:0] w);
    return {w, z, y, x};
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
      6, 7:             return $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return Q_ONE;
        endcase
      end
      default:          return $signed($urandom_range(0, 32'h400_0000)) - 32'sh200_0000;
    endcase
  endfunction

  function automatic lanes_t pick_lanes();
    return pack4(pick_value(), pick_value(), pick_value(), pick_value());
  endfunction

  function automatic logic signed [31:0] pick_scalar();
    if ($urandom_range(0, 99) < 80) begin
      return Q_ONE + $signed($urandom_range(0, 16384)) - 32'sd8192;
    end
    return pick_value();
  endfunction

  function automatic logic signed [3:0] pick_row();
    if ($urandom_range(0, 99) < 75) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] pick_opcode();
    int n;
    n = $urandom_range(0, 99);
    if (n < 30) return OPC_LOAD;
    if (n < 45) return OPC_READ;
    if (n < 65) return OPC_MXV;
    if (n < 85) return OPC_VXM;
    if (n < 93) return OPC_SCALE;
    return 3'($urandom_range(OPC_SCALE + 1, 7));
  endfunction

  task automatic send_item(logic [2:0] op, logic signed [3:0] row_sel, lanes_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    row_index <= row_sel;
    vec_x     <= v[0];
    vec_y     <= v[1];
    vec_z     <= v[2];
    vec_w     <= v[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_item(op, row_sel, v);
  endtask

  task automatic load_identity();
    for (int r = 0; r < 4; r++) begin
      send_item(OPC_LOAD, 4'(r), pack4(r == 0 ? Q_ONE : 32'sd0, r == 1 ? Q_ONE : 32'sd0,
                                       r == 2 ? Q_ONE : 32'sd0, r == 3 ? Q_ONE : 32'sd0));
    end
  endtask

  task automatic run_directed();
    for (int r = 0; r < 4; r++) send_item(OPC_READ, 4'(r), pick_lanes());
    send_item(OPC_MXV, 4'sd5, pack4(Q_ONE, 32'sh0002_0000, -32'sh0003_0000, Q_MAX));
    // row index out of range falls back to row 0
    send_item(OPC_LOAD, -4'sd8, pack4(Q_MAX, Q_MIN, 32'sd0, -32'sd1));
    send_item(OPC_LOAD, 4'sd1, pack4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(OPC_LOAD, 4'sd2, pack4(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_item(OPC_LOAD, 4'sd3, pack4(-32'sd1, 32'sd1, Q_ONE, -Q_ONE));
    send_item(OPC_READ, 4'sd7, '0);
    send_item(OPC_READ, -4'sd1, '0);
    send_item(OPC_READ, 4'sd4, '0);
    send_item(OPC_MXV, 4'sd0, pack4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(OPC_VXM, 4'sd3, pack4(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_item(OPC_VXM, -4'sd3, pack4(Q_ONE, 32'sd0, 32'sd0, 32'sd0));
    send_item(OPC_SCALE, 4'sd2, pack4(Q_MAX, 32'sd0, 32'sd0, 32'sd0));
    send_item(OPC_SCALE, 4'sd0, pack4(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_item(OPC_READ, 4'sd1, '0);
    send_item(OPC_SCALE, 4'sd1, pack4(32'sd0, -32'sd1, -32'sd1, -32'sd1));
    for (int u = OPC_SCALE + 1; u < 8; u++) begin
      send_item(3'(u), 4'(u), pack4(Q_MAX, Q_MIN, Q_ONE, -32'sd1));
    end
    load_identity();
    send_item(OPC_SCALE, 4'sd0, pack4(Q_ONE, 32'sd0, 32'sd0, 32'sd0));
    send_item(OPC_MXV, 4'sd0, pack4(32'sh0001_8000, -32'sh0000_4000, 32'sd7, -32'sd1));
  endtask

  task automatic run_random_phase();
    int          sent;
    logic [2:0]  op;
    lanes_t      v;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 30) begin
        for (int r = 0; r < 4; r++) send_item(OPC_LOAD, 4'(r), pick_lanes());
        sent += 4;
      end
      repeat ($urandom_range(4, 10)) begin
        op = pick_opcode();
        v  = pick_lanes();
        if (op == OPC_SCALE) v[0] = pick_scalar();
        send_item(op, pick_row(), v);
        if (op <= OPC_SCALE) sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_matrix();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      run_random_phase();
    end
    in_valid <= 1'b0;

    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/m4t_pkg.sv
hw/rtl/m4t_front.sv
hw/rtl/m4t_queue.sv
hw/rtl/m4t_back.sv
hw/rtl/matrix4_transform_unit_top.sv
test/tb_matrix4_transform_unit_top.sv
